[rtl/nfbc_pkg.sv]
// ----------------------------------------------------------------------------
// nfbc_pkg
// Shared types, constants and helpers of the nibble Feistel byte cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package nfbc_pkg;

  localparam int NIB_W = 4;
  localparam int BYTE_W = 8;
  localparam int POS_W = 5;
  localparam int KEY_W = 128;
  localparam int WORD_W = 64;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECRYPT_MODE = 2'd0,
    REG_KEY_LOW      = 2'd1,
    REG_KEY_HIGH     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [NIB_W-1:0] hi;
    logic [NIB_W-1:0] lo;
    logic [POS_W-1:0] j;
    logic             dec;
  } stage_t;

  // Even index takes the high nibble of its byte, odd index the low one.
  function automatic logic [NIB_W-1:0] key_nibble(input logic [KEY_W-1:0] key,
                                                  input logic [POS_W-1:0] j);
    logic [POS_W-1:0] n;
    n = j ^ POS_W'(1);
    return key[{n, 2'b00} +: NIB_W];
  endfunction

endpackage

`default_nettype wire

[rtl/nfbc_ifs.sv]
// ----------------------------------------------------------------------------
// nfbc_in_if / nfbc_out_if
// Valid/ready channels carrying input bytes and transformed bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nfbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       start_of_message;

  modport source (output valid, output data_in, output start_of_message, input ready);
  modport sink   (input valid, input data_in, input start_of_message, output ready);
endinterface

interface nfbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

[rtl/nfbc_entry.sv]
// ----------------------------------------------------------------------------
// nfbc_entry
// Input stage: tracks the key position and registers the first round index.
// ----------------------------------------------------------------------------
`default_nettype none

module nfbc_entry #(
  parameter int ROUNDS  = 8,
  parameter int NIBBLES = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            decrypt_mode,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [nfbc_pkg::BYTE_W-1:0]     data_in,
  input  wire logic                            start_of_message,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      nfbc_pkg::stage_t                out_data
);
  import nfbc_pkg::*;

  localparam int OFF = (ROUNDS - 1) % NIBBLES;
  localparam int ADV = ROUNDS % NIBBLES;

  logic [POS_W-1:0] key_position;
  logic [POS_W-1:0] p;
  logic [POS_W:0]   dsum;
  logic [POS_W:0]   asum;
  logic [POS_W-1:0] j0;
  logic [POS_W-1:0] key_position_next;
  logic             take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    p    = start_of_message ? '0 : key_position;
    dsum = {1'b0, p} + (POS_W+1)'(OFF);
    asum = {1'b0, p} + (POS_W+1)'(ADV);
    if (!decrypt_mode) begin
      j0 = p;
    end else if (dsum >= (POS_W+1)'(NIBBLES)) begin
      j0 = POS_W'(dsum - (POS_W+1)'(NIBBLES));
    end else begin
      j0 = dsum[POS_W-1:0];
    end
    if (asum >= (POS_W+1)'(NIBBLES)) begin
      key_position_next = POS_W'(asum - (POS_W+1)'(NIBBLES));
    end else begin
      key_position_next = asum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      key_position <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (take) begin
        key_position <= key_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.hi  <= data_in[BYTE_W-1:NIB_W];
      out_data.lo  <= data_in[NIB_W-1:0];
      out_data.j   <= j0;
      out_data.dec <= decrypt_mode;
    end
  end

endmodule

`default_nettype wire

[rtl/nfbc_round.sv]
// ----------------------------------------------------------------------------
// nfbc_round
// One registered Feistel round; steps the key index for the next round.
// ----------------------------------------------------------------------------
`default_nettype none

module nfbc_round #(
  parameter int NIBBLES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [nfbc_pkg::KEY_W-1:0]    key,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire nfbc_pkg::stage_t              in_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      nfbc_pkg::stage_t              out_data
);
  import nfbc_pkg::*;

  localparam logic [POS_W-1:0] LAST = POS_W'(NIBBLES - 1);

  stage_t res;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    res.hi  = in_data.lo;
    res.lo  = key_nibble(key, in_data.j) ^ NIB_W'(in_data.lo + in_data.j[NIB_W-1:0])
              ^ in_data.hi;
    res.dec = in_data.dec;
    if (in_data.dec) begin
      res.j = (in_data.j == '0) ? LAST : in_data.j - POS_W'(1);
    end else begin
      res.j = (in_data.j == LAST) ? '0 : in_data.j + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/nibble_feistel_byte_cipher.sv]
// ----------------------------------------------------------------------------
// nibble_feistel_byte_cipher
// Byte cipher built from nibble Feistel rounds, one pipeline stage per round.
// ----------------------------------------------------------------------------
// Takes one byte per clock and returns one byte per clock while the output
// is not stalled. The byte passes through ROUNDS+1 register stages: one
// entry stage that resolves the key position and is loaded at the input
// transfer, then one register stage per round. Every stage has its own
// valid bit and hands data on when the next stage is empty or moving, so a
// stalled output holds its byte while earlier stages keep filling. Key and
// mode registers are written through the configuration port. The user must
// write them only while no byte is in flight; the block itself does not
// enforce this.
`default_nettype none

module nibble_feistel_byte_cipher #(
  parameter int ROUNDS  = 8,
  parameter int NIBBLES = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [nfbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nfbc_pkg::WORD_W-1:0]       cfg_data,
  nfbc_in_if.sink                                in_ch,
  nfbc_out_if.source                             out_ch
);
  import nfbc_pkg::*;

  logic              decrypt_mode;
  logic [WORD_W-1:0] key_low_word;
  logic [WORD_W-1:0] key_high_word;
  logic [KEY_W-1:0]  key;

  stage_t st  [0:ROUNDS];
  logic   vld [0:ROUNDS];
  logic   rdy [0:ROUNDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode  <= 1'b0;
      key_low_word  <= '0;
      key_high_word <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DECRYPT_MODE: decrypt_mode  <= cfg_data[0];
        REG_KEY_LOW:      key_low_word  <= cfg_data;
        REG_KEY_HIGH:     key_high_word <= cfg_data;
        default: ;
      endcase
    end
  end

  assign key = {key_high_word, key_low_word};

  nfbc_entry #(
    .ROUNDS  (ROUNDS),
    .NIBBLES (NIBBLES)
  ) u_entry (
    .clk              (clk),
    .rst              (rst),
    .decrypt_mode     (decrypt_mode),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .data_in          (in_ch.data_in),
    .start_of_message (in_ch.start_of_message),
    .out_valid        (vld[0]),
    .out_ready        (rdy[0]),
    .out_data         (st[0])
  );

  for (genvar k = 0; k < ROUNDS; k++) begin : g_round
    nfbc_round #(
      .NIBBLES (NIBBLES)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_data   (st[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_data  (st[k+1])
    );
  end

  assign rdy[ROUNDS]     = out_ch.ready;
  assign out_ch.valid    = vld[ROUNDS];
  assign out_ch.data_out = {st[ROUNDS].lo, st[ROUNDS].hi};

endmodule

`default_nettype wire

[rtl/nfbc_checker.sv]
// ----------------------------------------------------------------------------
// nfbc_checker
// Port-level checks of the cipher pipeline: occupancy and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module nfbc_checker #(
  parameter int ROUNDS = 8
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_data
);

  localparam int CAP = ROUNDS + 1;
  localparam int CW  = $clog2(ROUNDS + 3);

  logic [CW-1:0] count;
  logic          in_xfer;
  logic          out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CW'(in_xfer) - CW'(out_xfer);
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output dropped or changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count != '0)
    else $error("output with no byte in flight");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAP))
    else $error("more bytes in flight than pipeline stages");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> in_ready)
    else $error("empty pipeline refuses input");

endmodule

bind nibble_feistel_byte_cipher nfbc_checker #(
  .ROUNDS (ROUNDS)
) u_nfbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data_out)
);

`default_nettype wire
